// ===== design/fch_pkg.sv =====
// ----------------------------------------------------------------------------
// fch_pkg
// shared types, codes and sizes of the fop-1 link control word report handler
// ----------------------------------------------------------------------------
package fch_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // sender state per channel
  typedef enum logic [2:0] {
    ST_ACTIVE       = 3'd1,
    ST_RETX_NO_WAIT = 3'd2,
    ST_RETX_WAIT    = 3'd3,
    ST_INIT_NO_BC   = 3'd4,
    ST_INIT_BC      = 3'd5,
    ST_INITIAL      = 3'd6
  } fop_state_t;

  // event codes
  localparam logic [4:0] EV_E1      = 5'd0;
  localparam logic [4:0] EV_E2      = 5'd1;
  localparam logic [4:0] EV_E3      = 5'd2;
  localparam logic [4:0] EV_E4      = 5'd3;
  localparam logic [4:0] EV_E5      = 5'd4;
  localparam logic [4:0] EV_E6      = 5'd5;
  localparam logic [4:0] EV_E7      = 5'd6;
  localparam logic [4:0] EV_E101    = 5'd7;
  localparam logic [4:0] EV_E102    = 5'd8;
  localparam logic [4:0] EV_E8      = 5'd9;
  localparam logic [4:0] EV_E9      = 5'd10;
  localparam logic [4:0] EV_E10     = 5'd11;
  localparam logic [4:0] EV_E11     = 5'd12;
  localparam logic [4:0] EV_E12     = 5'd13;
  localparam logic [4:0] EV_E12WAIT = 5'd14;
  localparam logic [4:0] EV_E13     = 5'd15;
  localparam logic [4:0] EV_E14     = 5'd16;
  localparam logic [4:0] EV_E15     = 5'd17;
  localparam logic [4:0] EV_IGNORED = 5'd18;

  // alert codes
  localparam logic [2:0] AL_NONE    = 3'd0;
  localparam logic [2:0] AL_SYNCH   = 3'd1;
  localparam logic [2:0] AL_CLCW    = 3'd2;
  localparam logic [2:0] AL_LOCKOUT = 3'd3;
  localparam logic [2:0] AL_NNR     = 3'd4;
  localparam logic [2:0] AL_LIMIT   = 3'd5;

  // cop-in-effect value for cop-1
  localparam logic [1:0] COP_ONE = 2'd1;

  // flag bit positions
  localparam int FLAG_RETX = 0;
  localparam int FLAG_WAIT = 1;
  localparam int FLAG_LOCK = 2;

  localparam logic [7:0] LIMIT_RESET = 8'd1;
  localparam logic [7:0] LIMIT_ONE   = 8'd1;

  typedef struct packed {
    logic [6:0] vc_id;
    logic [1:0] cop_in_effect;
    logic [2:0] clcw_flags;
    logic [7:0] report_value;
    logic [7:0] next_send_seq;
    logic [7:0] expected_ack_seq;
    logic [7:0] transmission_count;
  } report_t;

  typedef struct packed {
    logic [4:0] event_code;
    logic [2:0] new_state;
    logic [2:0] alert_code;
    logic       confirm_positive;
    logic       cancel_timer;
    logic       release_bc_copy;
    logic       remove_acked;
    logic       start_retransmission;
    logic       look_for_data;
  } result_t;

  // state table read request
  typedef struct packed {
    logic             en;
    logic [CH_AW-1:0] addr;
  } tbl_rd_t;

  // state table write back
  typedef struct packed {
    logic             en;
    logic [CH_AW-1:0] addr;
    fop_state_t       val;
  } tbl_wr_t;

endpackage

// ===== design/fch_state_table.sv =====
// ----------------------------------------------------------------------------
// fch_state_table
// per-channel sender state memory with registered read, valid bits and
// write-to-read forwarding for back to back beats on one channel
// ----------------------------------------------------------------------------
module fch_state_table (
  input  logic                clk,
  input  logic                rst,
  input  fch_pkg::tbl_rd_t    rd,
  input  fch_pkg::tbl_wr_t    wr,
  output fch_pkg::fop_state_t cur_state
);
  import fch_pkg::*;

  fop_state_t            mem [NUM_CHANNELS];
  fop_state_t            rd_data;
  logic [CH_AW-1:0]      rd_addr;
  logic [NUM_CHANNELS-1:0] vld;
  logic                  fwd_hit;
  fop_state_t            fwd_val;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.val;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
      rd_addr <= rd.addr;
      fwd_val <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        fwd_hit <= wr.en && (wr.addr == rd.addr);
      end
    end
  end

  // never-written entries read as initial
  always_comb begin
    if (fwd_hit) begin
      cur_state = fwd_val;
    end else if (vld[rd_addr]) begin
      cur_state = rd_data;
    end else begin
      cur_state = ST_INITIAL;
    end
  end

endmodule

// ===== design/fch_event_eval.sv =====
// ----------------------------------------------------------------------------
// fch_event_eval
// classifies one report into an event and applies its state transition
// ----------------------------------------------------------------------------
module fch_event_eval (
  input  fch_pkg::report_t    rpt,
  input  fch_pkg::fop_state_t cur_state,
  input  logic [7:0]          limit,
  output fch_pkg::result_t    res,
  output logic                in_range
);
  import fch_pkg::*;

  logic       retx;
  logic       wt;
  logic       lock;
  logic       act;
  logic       no_bc_init;
  logic [7:0] nr;
  logic [7:0] vs;
  logic [7:0] nnr;
  fop_state_t ns;

  assign retx = rpt.clcw_flags[FLAG_RETX];
  assign wt   = rpt.clcw_flags[FLAG_WAIT];
  assign lock = rpt.clcw_flags[FLAG_LOCK];
  assign nr   = rpt.report_value;
  assign vs   = rpt.next_send_seq;
  assign nnr  = rpt.expected_ack_seq;

  assign in_range = ({1'b0, rpt.vc_id} < 8'(NUM_CHANNELS));
  assign act = (cur_state == ST_ACTIVE) || (cur_state == ST_RETX_NO_WAIT) ||
               (cur_state == ST_RETX_WAIT);
  // states other than initial and initializing with bc frame
  assign no_bc_init = (cur_state != ST_INITIAL) && (cur_state != ST_INIT_BC);

  always_comb begin
    res                      = '0;
    ns                       = cur_state;
    res.event_code           = EV_IGNORED;
    if (!in_range) begin
      ns = ST_INITIAL;
    end else if (rpt.cop_in_effect != COP_ONE) begin
      res.event_code = EV_E15;
      if (cur_state != ST_INITIAL) begin
        res.alert_code = AL_CLCW;
        ns = ST_INITIAL;
      end
    end else if (lock) begin
      res.event_code = EV_E14;
      if (no_bc_init) begin
        res.alert_code = AL_LOCKOUT;
        ns = ST_INITIAL;
      end
    end else if (nr == vs) begin
      if (retx) begin
        res.event_code = EV_E4;
        if (no_bc_init) begin
          res.alert_code = AL_SYNCH;
          ns = ST_INITIAL;
        end
      end else if (wt) begin
        res.event_code = EV_E3;
        if (cur_state != ST_INITIAL) begin
          res.alert_code = AL_CLCW;
          ns = ST_INITIAL;
        end
      end else if (nr == nnr) begin
        res.event_code = EV_E1;
        if (cur_state == ST_RETX_NO_WAIT || cur_state == ST_RETX_WAIT) begin
          res.alert_code = AL_SYNCH;
          ns = ST_INITIAL;
        end else if (cur_state == ST_INIT_NO_BC) begin
          res.confirm_positive = 1'b1;
          res.cancel_timer     = 1'b1;
          ns = ST_ACTIVE;
        end else if (cur_state == ST_INIT_BC) begin
          res.confirm_positive = 1'b1;
          res.release_bc_copy  = 1'b1;
          res.cancel_timer     = 1'b1;
          ns = ST_ACTIVE;
        end
      end else begin
        res.event_code = EV_E2;
        if (act) begin
          res.remove_acked  = 1'b1;
          res.cancel_timer  = 1'b1;
          res.look_for_data = 1'b1;
          ns = ST_ACTIVE;
        end
      end
    end else if (nr < vs && nr >= nnr) begin
      // plain window compare, no modulo wrap
      if (!retx) begin
        if (wt) begin
          res.event_code = EV_E7;
          if (act) begin
            res.alert_code = AL_CLCW;
            ns = ST_INITIAL;
          end
        end else if (nr == nnr) begin
          res.event_code = EV_E5;
          if (cur_state == ST_RETX_NO_WAIT || cur_state == ST_RETX_WAIT) begin
            res.alert_code = AL_SYNCH;
            ns = ST_INITIAL;
          end
        end else begin
          res.event_code = EV_E6;
          if (act) begin
            res.remove_acked  = 1'b1;
            res.look_for_data = 1'b1;
            ns = ST_ACTIVE;
          end
        end
      end else if (limit == LIMIT_ONE) begin
        if (nr != nnr) begin
          res.event_code = EV_E101;
          if (act) begin
            res.remove_acked = 1'b1;
            res.alert_code   = AL_LIMIT;
            ns = ST_INITIAL;
          end
        end else begin
          res.event_code = EV_E102;
          if (act) begin
            res.alert_code = AL_LIMIT;
            ns = ST_INITIAL;
          end
        end
      end else if (nr != nnr) begin
        if (!wt) begin
          res.event_code = EV_E8;
          if (act) begin
            res.remove_acked         = 1'b1;
            res.start_retransmission = 1'b1;
            res.look_for_data        = 1'b1;
            ns = ST_RETX_NO_WAIT;
          end
        end else begin
          res.event_code = EV_E9;
          if (act) begin
            res.remove_acked = 1'b1;
            ns = ST_RETX_WAIT;
          end
        end
      end else if (rpt.transmission_count < limit) begin
        if (!wt) begin
          res.event_code = EV_E10;
          if (cur_state == ST_ACTIVE || cur_state == ST_RETX_WAIT) begin
            res.start_retransmission = 1'b1;
            res.look_for_data        = 1'b1;
            ns = ST_RETX_NO_WAIT;
          end
        end else begin
          res.event_code = EV_E11;
          if (act) begin
            ns = ST_RETX_WAIT;
          end
        end
      end else begin
        if (!wt) begin
          res.event_code = EV_E12;
          if (act) begin
            ns = ST_RETX_NO_WAIT;
          end
        end else begin
          res.event_code = EV_E12WAIT;
          if (act) begin
            ns = ST_RETX_WAIT;
          end
        end
      end
    end else begin
      res.event_code = EV_E13;
      if (no_bc_init) begin
        res.alert_code = AL_NNR;
        ns = ST_INITIAL;
      end
    end
    res.new_state = ns;
  end

endmodule

// ===== design/fop_clcw_report_handler.sv =====
// ----------------------------------------------------------------------------
// fop_clcw_report_handler
// fop-1 sender side processing of received link control word reports
// ----------------------------------------------------------------------------
// One report beat in, one result beat out. A beat is taken in every cycle
// unless rpt_stall is raised by a stalled result. Each report passes an input
// stage and then the result register, since the 64-entry channel state memory
// has a registered read port: the input stage holds the report while the read
// completes, and the result register follows it. Reports for the same channel
// in consecutive cycles see the state left by the previous one through a
// forwarding path. All channels start in the initial state after reset by way
// of per-entry valid bits; no clearing pass is needed. The transmission limit
// is written through the cfg channel, which is always ready, and should only
// change while no reports are in flight.
module fop_clcw_report_handler (
  input  logic              clk,
  input  logic              rst,
  input  logic              rpt_valid,
  output logic              rpt_stall,
  input  fch_pkg::report_t  rpt,
  output logic              res_valid,
  input  logic              res_stall,
  output fch_pkg::result_t  res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import fch_pkg::*;

  // shared transmission limit
  logic [7:0] limit;

  // input stage: report waiting for its state read
  logic       s1_valid;
  report_t    s1_rpt;
  logic       s1_adv;
  logic       rpt_acc;

  // table interface
  tbl_rd_t    tbl_rd;
  tbl_wr_t    tbl_wr;
  fop_state_t cur_state;

  // evaluation
  result_t    eval_res;
  logic       eval_in_range;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // input stage moves on when the result register is free or being drained
  assign s1_adv    = s1_valid && !(res_valid && res_stall);
  assign rpt_stall = s1_valid && !s1_adv;
  assign rpt_acc   = rpt_valid && !rpt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rpt_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt_acc) begin
      s1_rpt <= rpt;
    end
  end

  // read the channel state as the report enters
  assign tbl_rd.en   = rpt_acc;
  assign tbl_rd.addr = rpt.vc_id[CH_AW-1:0];

  fch_state_table u_table (
    .clk       (clk),
    .rst       (rst),
    .rd        (tbl_rd),
    .wr        (tbl_wr),
    .cur_state (cur_state)
  );

  fch_event_eval u_eval (
    .rpt       (s1_rpt),
    .cur_state (cur_state),
    .limit     (limit),
    .res       (eval_res),
    .in_range  (eval_in_range)
  );

  // write back the new state as the result is registered
  // out-of-range channels leave the table alone
  assign tbl_wr.en   = s1_adv && eval_in_range;
  assign tbl_wr.addr = s1_rpt.vc_id[CH_AW-1:0];
  assign tbl_wr.val  = fop_state_t'(eval_res.new_state);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= eval_res;
    end
  end

  // an empty input stage never stalls the report side
  a_no_idle_stall : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !rpt_stall)
    else $error("report stalled with empty input stage");

  // ignored channels report the fixed initial state and no alert
  a_ignored_result : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.event_code == EV_IGNORED) |->
      (res.new_state == ST_INITIAL && res.alert_code == AL_NONE &&
       !res.remove_acked && !res.cancel_timer))
    else $error("ignored report carries state change or strobe");

  // positive confirm only on entry into active
  a_confirm_active : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.confirm_positive) |-> (res.new_state == ST_ACTIVE))
    else $error("confirm without active state");

  // retransmission start lands in retransmit without wait
  a_retx_state : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.start_retransmission) |-> (res.new_state == ST_RETX_NO_WAIT))
    else $error("retransmission started into wrong state");

  // write back happens only while a result is being registered
  a_write_with_result : assert property (@(posedge clk) disable iff (rst)
    tbl_wr.en |=> res_valid)
    else $error("state write without result");

endmodule
